// ===== hw/rtl/crcac_pkg.sv =====
`timescale 1ns / 1ps
package crcac_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] verdict_t;
    typedef logic [31:0] crc_t;

    localparam crc_t CRC_POLY_REFL = 32'hEDB88320;
    localparam crc_t CRC_INIT      = 32'hFFFFFFFF;
    localparam crc_t CRC_XOROUT    = 32'hFFFFFFFF;
    localparam int   FCS_LEN       = 4;

    localparam verdict_t VERDICT_NONE = 2'd0;
    localparam verdict_t VERDICT_PASS = 2'd1;
    localparam verdict_t VERDICT_FAIL = 2'd2;

    // reflected crc-32, one byte, unrolled
    function automatic crc_t crc_byte(crc_t c, byte_t b);
        crc_t x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY_REFL) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ===== hw/rtl/crcac_in_if.sv =====
`timescale 1ns / 1ps
interface crcac_in_if;
    import crcac_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/crcac_out_if.sv =====
`timescale 1ns / 1ps
interface crcac_out_if;
    import crcac_pkg::*;

    logic        valid;
    logic        ready;
    byte_t       out_byte;
    logic        byte_valid;
    logic        out_last;
    verdict_t    verdict;
    logic [31:0] pass_count;
    logic [31:0] fail_count;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    output verdict, output pass_count, output fail_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                    input verdict, input pass_count, input fail_count, output ready);
endinterface

// ===== hw/rtl/crc32_append_and_check_core.sv =====
`timescale 1ns / 1ps
// result beats are driven from an output register loaded when the causing input is taken
// throughput: one byte per cycle unless stalled, set by the byte crc update and output register
// append mode: the last byte adds four crc beats, input is held off until those beats are sent
// check mode: a packet's first four bytes go into the tail line and give no beat unless last
// reset (async, active low): mode append, crc all ones, counters zero, output empty
module crc32_append_and_check_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    crcac_in_if.sink           din,
    crcac_out_if.source        dout
);
    import crcac_pkg::*;

    logic                   mode_reg;
    crc_t                   crc_reg, crc_next;
    logic [2:0]             seen_reg, seen_next;
    byte_t                  tail_reg [FCS_LEN];
    byte_t                  tail_next [FCS_LEN];
    logic [COUNT_WIDTH-1:0] pass_reg, pass_next;
    logic [COUNT_WIDTH-1:0] fail_reg, fail_next;
    crc_t                   fcs_reg, fcs_next;
    logic [2:0]             fcs_left_reg, fcs_left_next;

    logic        ovalid_reg;
    byte_t       obyte_reg;
    logic        obv_reg;
    logic        olast_reg;
    verdict_t    overdict_reg;
    logic [31:0] opass_reg;
    logic [31:0] ofail_reg;

    logic        slot_free;
    logic        fcs_busy;
    logic        in_acc;
    logic        have_pop;
    logic        full;
    crc_t        crc_upd;
    crc_t        crc_chk;
    crc_t        recv;
    logic        res_valid;
    byte_t       res_byte;
    logic        res_bv;
    logic        res_last;
    verdict_t    res_verdict;
    logic [63:0] pass_ext;
    logic [63:0] fail_ext;
    logic [31:0] pass_show;
    logic [31:0] fail_show;

    assign slot_free = !ovalid_reg || dout.ready;
    assign fcs_busy  = (fcs_left_reg != 3'd0);
    assign din.ready = slot_free && !fcs_busy;
    assign in_acc    = din.valid && din.ready;
    assign have_pop  = (seen_reg >= 3'(FCS_LEN));
    assign crc_upd   = crc_byte(crc_reg, mode_reg ? tail_reg[0] : din.in_byte);

    always_comb
    begin
        crc_next      = crc_reg;
        seen_next     = seen_reg;
        tail_next     = tail_reg;
        pass_next     = pass_reg;
        fail_next     = fail_reg;
        fcs_next      = fcs_reg;
        fcs_left_next = fcs_left_reg;
        crc_chk       = crc_reg;
        full          = 1'b0;
        recv          = '0;
        res_valid     = 1'b0;
        res_byte      = '0;
        res_bv        = 1'b0;
        res_last      = 1'b0;
        res_verdict   = VERDICT_NONE;

        if (cfg_we)
        begin
            crc_next  = CRC_INIT;
            seen_next = '0;
        end
        else if (fcs_busy)
        begin
            if (slot_free)
            begin
                res_valid     = 1'b1;
                res_byte      = fcs_reg[7:0];
                res_bv        = 1'b1;
                res_last      = (fcs_left_reg == 3'd1);
                fcs_next      = fcs_reg >> 8;
                fcs_left_next = fcs_left_reg - 3'd1;
            end
        end
        else if (in_acc)
        begin
            if (!mode_reg)
            begin
                res_valid = 1'b1;
                res_byte  = din.in_byte;
                res_bv    = 1'b1;
                if (din.in_last)
                begin
                    fcs_next      = crc_upd ^ CRC_XOROUT;
                    fcs_left_next = 3'(FCS_LEN);
                    crc_next      = CRC_INIT;
                end
                else
                begin
                    crc_next = crc_upd;
                end
            end
            else
            begin
                // tail line: oldest byte leaves into the crc once four are held
                if (have_pop)
                begin
                    crc_chk = crc_upd;
                    for (int i = 0; i < FCS_LEN - 1; i++)
                    begin
                        tail_next[i] = tail_reg[i + 1];
                    end
                    tail_next[FCS_LEN - 1] = din.in_byte;
                end
                else
                begin
                    tail_next[seen_reg[1:0]] = din.in_byte;
                    seen_next = seen_reg + 3'd1;
                end
                full = have_pop || (seen_reg == 3'(FCS_LEN - 1));
                recv = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};

                if (din.in_last)
                begin
                    if (full && ((crc_chk ^ CRC_XOROUT) == recv))
                    begin
                        res_verdict = VERDICT_PASS;
                        if (pass_reg != '1)
                        begin
                            pass_next = pass_reg + COUNT_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        res_verdict = VERDICT_FAIL;
                        if (fail_reg != '1)
                        begin
                            fail_next = fail_reg + COUNT_WIDTH'(1);
                        end
                    end
                    res_valid = 1'b1;
                    res_byte  = have_pop ? tail_reg[0] : '0;
                    res_bv    = have_pop;
                    res_last  = 1'b1;
                    crc_next  = CRC_INIT;
                    seen_next = '0;
                end
                else
                begin
                    crc_next  = crc_chk;
                    res_valid = have_pop;
                    res_byte  = tail_reg[0];
                    res_bv    = 1'b1;
                end
            end
        end
    end

    // counters wider than 32 bits are shown saturated
    always_comb
    begin
        pass_ext  = 64'(pass_next);
        fail_ext  = 64'(fail_next);
        pass_show = (|pass_ext[63:32]) ? 32'hFFFFFFFF : pass_ext[31:0];
        fail_show = (|fail_ext[63:32]) ? 32'hFFFFFFFF : fail_ext[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            crc_reg      <= CRC_INIT;
            seen_reg     <= '0;
            pass_reg     <= '0;
            fail_reg     <= '0;
            fcs_left_reg <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            crc_reg      <= crc_next;
            seen_reg     <= seen_next;
            pass_reg     <= pass_next;
            fail_reg     <= fail_next;
            fcs_left_reg <= fcs_left_next;
            if (slot_free)
            begin
                ovalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        fcs_reg  <= fcs_next;
        if (slot_free && res_valid)
        begin
            obyte_reg    <= res_byte;
            obv_reg      <= res_bv;
            olast_reg    <= res_last;
            overdict_reg <= res_verdict;
            opass_reg    <= pass_show;
            ofail_reg    <= fail_show;
        end
    end

    assign dout.valid      = ovalid_reg;
    assign dout.out_byte   = obyte_reg;
    assign dout.byte_valid = obv_reg;
    assign dout.out_last   = olast_reg;
    assign dout.verdict    = overdict_reg;
    assign dout.pass_count = opass_reg;
    assign dout.fail_count = ofail_reg;

endmodule

// ===== hw/rtl/crcac_checker.sv =====
`timescale 1ns / 1ps
module crcac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        out_last,
    input logic [1:0]  verdict,
    input logic [31:0] pass_count,
    input logic [31:0] fail_count
);
    import crcac_pkg::*;

    logic        seen_reg;
    logic [31:0] last_pass_reg;
    logic [31:0] last_fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_pass_reg <= '0;
            last_fail_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            seen_reg      <= 1'b1;
            last_pass_reg <= pass_count;
            last_fail_reg <= fail_count;
        end
    end

    // a verdict only rides on the closing beat of a packet
    a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict != VERDICT_NONE) |-> out_last)
        else $error("verdict on a beat that is not last");

    // a beat without a byte is a verdict-only closing beat
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_last && (verdict != VERDICT_NONE))
        else $error("empty beat without verdict");

    // counters never move backward between delivered beats
    a_counts_grow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && seen_reg |->
            (pass_count >= last_pass_reg) && (fail_count >= last_fail_reg))
        else $error("counter went backward");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_byte) && $stable(out_last) && $stable(verdict))
        else $error("output changed while stalled");

endmodule

bind crc32_append_and_check_core crcac_checker u_crcac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_byte   (dout.out_byte),
    .byte_valid (dout.byte_valid),
    .out_last   (dout.out_last),
    .verdict    (dout.verdict),
    .pass_count (dout.pass_count),
    .fail_count (dout.fail_count)
);
